// File: sv/buddy_allocator_unit_defines.svh
// Assertion macros for the buddy allocator unit.
// Expects clk and rst in the scope of the including module.
`ifndef BUDDY_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BAL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BAL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/bal_pkg.sv
// Shared types and codes for the buddy allocator unit.
// No dependencies.
package bal_pkg;

  typedef enum logic [1:0] {
    ND_UNUSED = 2'd0,
    ND_FREE   = 2'd1,
    ND_SPLIT  = 2'd2,
    ND_ALLOC  = 2'd3
  } node_st_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    FS_INIT,
    FS_IDLE,
    FS_A_RD,
    FS_A_SPL,
    FS_F_RD,
    FS_UP_RD,
    FS_UP_EV,
    FS_DONE
  } fsm_t;

  localparam int unsigned REQ_W  = 13;
  localparam int unsigned ADDR_W = 12;

endpackage

// File: sv/bal_size_order.sv
// Size class of an allocate request: smallest order whose block holds it.
// Uses bal_pkg for field widths.
module bal_size_order #(
  parameter int LEVELS          = 8,
  parameter int MIN_BLOCK_BYTES = 16
) (
  input  logic [bal_pkg::REQ_W-1:0]     request_bytes,
  output logic [$clog2(LEVELS+2)-1:0]   want
);
  import bal_pkg::*;

  localparam int LW = $clog2(LEVELS+2);

  logic [LEVELS:0] below;

  // block sizes grow monotonically, so the order is the count of sizes too small
  always_comb begin
    for (int w = 0; w <= LEVELS; w++) begin
      below[w] = ((33'(MIN_BLOCK_BYTES) << w) < 33'(request_bytes));
    end
  end

  assign want = LW'($countones(below));

endmodule

// File: sv/buddy_allocator_unit.sv
// Buddy allocator unit: node-state tree in one synchronous memory, walked by a sequencer.
// Allocate and free go down one level a cycle, then on success back up to the root,
// reading the buddy and then writing the parent at each level; an oversized request or a
// free outside the pool goes straight to the result without walking the tree.
// One beat in flight: the next input beat is taken only after the result loads into the
// output register, and the result waits while the output is held off.
// rst (synchronous) and every pool_levels write go to FS_INIT to write the root entry
// as free; no other entry is cleared, as only entries under a split node are ever read.
module buddy_allocator_unit #(
  parameter int LEVELS          = 8,
  parameter int MIN_BLOCK_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // request_bytes[12:0], address[24:13], zero[31:25]
  input  logic [0:0]  s_tuser,   // operation[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // block_offset[11:0], block_order[15:12]
  output logic [1:0]  m_tuser,   // status[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bal_pkg::*;

  localparam int unsigned NODES    = (2 ** (LEVELS + 1)) - 1;
  localparam int          IW       = LEVELS + 1;
  localparam int          LW       = $clog2(LEVELS + 2);
  localparam int          WW       = LW + 2;
  localparam longint      POOL_MAX = longint'(MIN_BLOCK_BYTES) << LEVELS;
  localparam int          BW       = $clog2(POOL_MAX + 1);
  localparam int          SW       = (BW > 13) ? BW : 13;
  localparam logic [SW-1:0] MIN_W  = SW'(MIN_BLOCK_BYTES);

  // tree memory: {state, longest free order + 1 (0 = none)}
  logic [WW-1:0] node_mem [NODES];
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [WW-1:0] mem_wd;
  logic          mem_re;
  logic [IW-1:0] mem_ra;
  logic [IW-1:0] mem_rb;
  logic [WW-1:0] rda;
  logic [WW-1:0] rdb;

  fsm_t state, state_next;

  logic [LW-1:0]     pl, pl_next;
  logic [LW-1:0]     want, want_next;
  logic [ADDR_W-1:0] addr, addr_next;
  logic [IW-1:0]     idx, idx_next;
  logic [LW-1:0]     ord, ord_next;
  logic [SW-1:0]     start, start_next;
  logic              at_root, at_root_next;
  logic [LW-1:0]     cur_lng, cur_lng_next;
  logic              merge, merge_next;
  status_t           res_status, res_status_next;
  logic [SW-1:0]     res_off, res_off_next;
  logic [LW-1:0]     res_order, res_order_next;
  logic              out_valid;
  status_t           out_status;
  logic [11:0]       out_off;
  logic [3:0]        out_order;

  logic              cfg_wr;
  logic              acc;
  op_t               in_op;
  logic [REQ_W-1:0]  in_req;
  logic [ADDR_W-1:0] in_addr;
  logic [LW-1:0]     want_in;
  logic              in_fail;
  logic [SW-1:0]     pool_bytes;
  logic              out_free;
  logic              oversize;
  logic              ascending;

  node_st_t          cw_st;
  logic [LW-1:0]     cw_lng;
  logic [IW-1:0]     nidx;
  logic [SW-1:0]     nstart;
  logic [IW-1:0]     n_left;
  logic [IW-1:0]     n_right;
  logic              a_none;
  logic              a_hit;
  logic              a_split;
  logic              a_kids;

  node_st_t          ra_st;
  logic [LW-1:0]     ra_lng;
  node_st_t          rb_st;
  logic [LW-1:0]     rb_lng;
  logic              f_found;
  logic              f_down;
  logic              f_right;
  logic [SW-1:0]     half_dn;
  logic [IW-1:0]     i_left;

  logic [IW-1:0]     parent;
  logic [IW-1:0]     buddy;
  logic              up_merge;
  node_st_t          pw_st;
  logic [LW-1:0]     pw_lng;

  bal_size_order #(
    .LEVELS          (LEVELS),
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
  ) u_size (
    .request_bytes (in_req),
    .want          (want_in)
  );

  // ---- APB ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = 32'(pl);

  always_comb begin
    pl_next = pl;
    if (cfg_wr) begin
      pl_next = (32'(pwdata[3:0]) > 32'(LEVELS)) ? LW'(LEVELS) : LW'(pwdata[3:0]);
    end
  end

  // ---- stream side ----
  assign s_tready = (state == FS_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign in_op    = op_t'(s_tuser[0]);
  assign in_req   = s_tdata[12:0];
  assign in_addr  = s_tdata[24:13];
  assign pool_bytes = MIN_W << pl;
  assign in_fail  = (in_op == OP_ALLOC) ? (want_in > pl) : (SW'(in_addr) >= pool_bytes);
  assign out_free = !out_valid || m_tready;

  assign ra_st  = node_st_t'(rda[WW-1:LW]);
  assign ra_lng = rda[LW-1:0];
  assign rb_st  = node_st_t'(rdb[WW-1:LW]);
  assign rb_lng = rdb[LW-1:0];

  // ---- decode ----
  always_comb begin
    nidx   = idx;
    nstart = start;
    cw_st  = ra_st;
    cw_lng = ra_lng;
    if (state == FS_A_SPL) begin
      cw_st  = ND_FREE;
      cw_lng = LW'(ord + 1'b1);
    end else if (!at_root && (ra_lng <= want)) begin
      // left child cannot hold it, take the right one
      nidx   = idx + 1'b1;
      nstart = start + (MIN_W << ord);
      cw_st  = rb_st;
      cw_lng = rb_lng;
    end
    n_left  = {nidx[IW-2:0], 1'b1};
    n_right = n_left + 1'b1;
    a_none  = (cw_lng <= want);
    a_hit   = (cw_st == ND_FREE) && (ord == want);
    a_split = (cw_st == ND_FREE) && (ord != want);
    a_kids  = (cw_st == ND_SPLIT);

    i_left  = {idx[IW-2:0], 1'b1};
    half_dn = MIN_W << (ord - 1'b1);
    f_found = (ra_st == ND_ALLOC) && (SW'(addr) == start);
    f_down  = (ra_st == ND_SPLIT) && (ord != '0);
    f_right = (SW'(addr) >= (start + half_dn));

    parent   = (idx - 1'b1) >> 1;
    buddy    = idx[0] ? (idx + 1'b1) : (idx - 1'b1);
    up_merge = merge && (ra_st == ND_FREE);
    if (up_merge) begin
      pw_st  = ND_FREE;
      pw_lng = LW'(cur_lng + 1'b1);
    end else begin
      pw_st  = ND_SPLIT;
      pw_lng = (cur_lng > ra_lng) ? cur_lng : ra_lng;
    end
  end

  // ---- next state ----
  always_comb begin
    state_next = state;
    case (state)
      FS_INIT: state_next = FS_IDLE;
      FS_IDLE: begin
        if (acc) begin
          if (in_fail)               state_next = FS_DONE;
          else if (in_op == OP_ALLOC) state_next = FS_A_RD;
          else                        state_next = FS_F_RD;
        end
      end
      FS_A_RD, FS_A_SPL: begin
        if (a_none)       state_next = FS_DONE;
        else if (a_hit)   state_next = (nidx == '0) ? FS_DONE : FS_UP_RD;
        else if (a_split) state_next = FS_A_SPL;
        else if (a_kids)  state_next = FS_A_RD;
        else              state_next = FS_DONE;
      end
      FS_F_RD: begin
        if (f_found)     state_next = (idx == '0) ? FS_DONE : FS_UP_RD;
        else if (f_down) state_next = FS_F_RD;
        else             state_next = FS_DONE;
      end
      FS_UP_RD: state_next = FS_UP_EV;
      FS_UP_EV: state_next = (parent == '0) ? FS_DONE : FS_UP_RD;
      FS_DONE:  state_next = out_free ? FS_IDLE : FS_DONE;
      default:  state_next = FS_INIT;
    endcase
    if (cfg_wr) state_next = FS_INIT;
  end

  // ---- datapath and memory controls ----
  always_comb begin
    want_next       = want;
    addr_next       = addr;
    idx_next        = idx;
    ord_next        = ord;
    start_next      = start;
    at_root_next    = at_root;
    cur_lng_next    = cur_lng;
    merge_next      = merge;
    res_status_next = res_status;
    res_off_next    = res_off;
    res_order_next  = res_order;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = '0;
    mem_rb = '0;
    case (state)
      FS_INIT: begin
        mem_we = 1'b1;
        mem_wd = {ND_FREE, LW'(pl + 1'b1)};
      end
      FS_IDLE: begin
        if (acc) begin
          want_next      = want_in;
          addr_next      = in_addr;
          idx_next       = '0;
          ord_next       = pl;
          start_next     = '0;
          at_root_next   = 1'b1;
          merge_next     = 1'b0;
          res_off_next   = '0;
          res_order_next = '0;
          if (!in_fail)                res_status_next = ST_OK;
          else if (in_op == OP_ALLOC) res_status_next = ST_NO_SPACE;
          else                        res_status_next = ST_BAD_FREE;
          mem_re = 1'b1;
        end
      end
      FS_A_RD, FS_A_SPL: begin
        at_root_next = 1'b0;
        if (a_none) begin
          res_status_next = ST_NO_SPACE;
        end else if (a_hit) begin
          mem_we         = 1'b1;
          mem_wa         = nidx;
          mem_wd         = {ND_ALLOC, LW'(0)};
          cur_lng_next   = '0;
          idx_next       = nidx;
          res_off_next   = nstart;
          res_order_next = want;
        end else if (a_split) begin
          // right half becomes a free block, keep going down the left
          mem_we     = 1'b1;
          mem_wa     = n_right;
          mem_wd     = {ND_FREE, ord};
          idx_next   = n_left;
          ord_next   = ord - 1'b1;
          start_next = nstart;
        end else if (a_kids) begin
          mem_re     = 1'b1;
          mem_ra     = n_left;
          mem_rb     = n_right;
          idx_next   = n_left;
          ord_next   = ord - 1'b1;
          start_next = nstart;
        end else begin
          res_status_next = ST_NO_SPACE;
        end
      end
      FS_F_RD: begin
        if (f_found) begin
          mem_we         = 1'b1;
          mem_wa         = idx;
          mem_wd         = {ND_FREE, LW'(ord + 1'b1)};
          cur_lng_next   = LW'(ord + 1'b1);
          merge_next     = 1'b1;
          res_off_next   = start;
          res_order_next = ord;
        end else if (f_down) begin
          ord_next = ord - 1'b1;
          mem_re   = 1'b1;
          if (f_right) begin
            idx_next   = i_left + 1'b1;
            start_next = start + half_dn;
            mem_ra     = i_left + 1'b1;
          end else begin
            idx_next = i_left;
            mem_ra   = i_left;
          end
        end else begin
          res_status_next = ST_BAD_FREE;
        end
      end
      FS_UP_RD: begin
        mem_re = 1'b1;
        mem_ra = buddy;
      end
      FS_UP_EV: begin
        mem_we       = 1'b1;
        mem_wa       = parent;
        mem_wd       = {pw_st, pw_lng};
        cur_lng_next = pw_lng;
        merge_next   = up_merge;
        idx_next     = parent;
      end
      default: begin
      end
    endcase
  end

  // ---- tree memory ----
  always_ff @(posedge clk) begin
    if (mem_we) node_mem[mem_wa] <= mem_wd;
    if (mem_re) begin
      rda <= node_mem[mem_ra];
      rdb <= node_mem[mem_rb];
    end
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FS_INIT;
      pl        <= (LEVELS < 8) ? LW'(LEVELS) : LW'(8);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pl    <= pl_next;
      if (state == FS_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    want       <= want_next;
    addr       <= addr_next;
    idx        <= idx_next;
    ord        <= ord_next;
    start      <= start_next;
    at_root    <= at_root_next;
    cur_lng    <= cur_lng_next;
    merge      <= merge_next;
    res_status <= res_status_next;
    res_off    <= res_off_next;
    res_order  <= res_order_next;
    if (state == FS_DONE && out_free) begin
      out_status <= res_status;
      out_off    <= res_off[11:0];
      out_order  <= 4'(res_order);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_order, out_off};
  assign m_tuser  = out_status;

  // ---- checks ----
  assign oversize  = acc && !cfg_wr && (in_op == OP_ALLOC) && (want_in > pl);
  assign ascending = (state == FS_UP_RD) || (state == FS_UP_EV);

  `include "buddy_allocator_unit_defines.svh"

  `BAL_ASSERT_NXT(a_busy_after_beat, acc, !s_tready, "accepted beat left input ready")
  `BAL_ASSERT_NXT(a_init_after_cfg, cfg_wr, state == FS_INIT, "pool write did not re-initialise")
  `BAL_ASSERT_NXT(a_big_req_done, oversize, state == FS_DONE, "oversized request walked the tree")
  `BAL_ASSERT_IMP(a_up_not_root, ascending, idx != '0, "ascent reached past the root")

endmodule
